// File: design/nsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_pkg
// Types, character constants and the character decode for the numeric
// string recogniser.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int unsigned CharWidth = 8;

	typedef logic [CharWidth-1:0] char_t;

	// Character constants used by the recogniser.
	localparam char_t ChNul   = 8'h00;
	localparam char_t ChSpace = 8'h20;
	localparam char_t ChTab   = 8'h09;
	localparam char_t ChLf    = 8'h0A;
	localparam char_t ChCr    = 8'h0D;
	localparam char_t ChPlus  = 8'h2B;
	localparam char_t ChMinus = 8'h2D;
	localparam char_t ChPoint = 8'h2E;
	localparam char_t ChLowE  = 8'h65;
	localparam char_t ChUpE   = 8'h45;
	localparam char_t ChPct   = 8'h25;
	localparam char_t ChZero  = 8'h30;
	localparam char_t ChNine  = 8'h39;

	// Scan phase of the recogniser.
	typedef enum logic [3:0] {
		PH_LEAD   = 4'd0,
		PH_SIGN   = 4'd1,
		PH_INT    = 4'd2,
		PH_FRAC   = 4'd3,
		PH_EXP    = 4'd4,
		PH_ESIGN  = 4'd5,
		PH_EDIG   = 4'd6,
		PH_PCT    = 4'd7,
		PH_TRAIL  = 4'd8,
		PH_REJECT = 4'd9
	} phase_t;

	// Decoded class of one character.
	typedef struct packed {
		logic is_nul;
		logic is_space;
		logic is_sign;
		logic is_digit;
		logic is_point;
		logic is_exp;
		logic is_pct;
	} char_class_t;

	// Verdict for one completed string.
	typedef struct packed {
		logic is_numeric;
		logic has_percent;
	} verdict_t;

	// Sort one character into its classes.
	function automatic char_class_t classify(input char_t c);
		char_class_t k;
		k.is_nul   = (c == ChNul);
		k.is_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
		k.is_sign  = (c == ChPlus) || (c == ChMinus);
		k.is_digit = c inside {[ChZero:ChNine]};
		k.is_point = (c == ChPoint);
		k.is_exp   = (c == ChLowE) || (c == ChUpE);
		k.is_pct   = (c == ChPct);
		return k;
	endfunction

endpackage

// File: design/numeric_string_recognizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_string_recognizer_top
// Recognises decimal number literals one character word at a time.
// ----------------------------------------------------------------------------
// One character word is taken per cycle. Words land in an input register,
// where a small phase machine steps on them; a zero byte ends the
// string and puts one verdict word into the output register. The verdict is
// offered from the output register once its terminator steps the phase
// machine, and a new word is taken every cycle; the only stall is a
// terminator reaching a full output register whose verdict is not yet taken.
module numeric_string_recognizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_numeric,
	output logic       has_percent
);
	import nsr_pkg::*;

	logic     vld_s1;
	char_t    ch_s1;
	logic     out_free;
	logic     is_term;
	logic     step;
	verdict_t verdict;
	verdict_t verdict_q;
	logic     out_vld_q;

	// The stage advances unless a terminator meets a held verdict.
	assign out_free = !out_vld_q || out_ready;
	assign is_term  = (ch_s1 == ChNul);
	assign step     = vld_s1 && (!is_term || out_free);
	assign in_ready = !vld_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= ch;
		end
	end

	nsr_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ch      (ch_s1),
		.verdict (verdict)
	);

	// Output register for the verdict word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step && is_term) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_term) begin
			verdict_q <= verdict;
		end
	end

	assign out_valid   = out_vld_q;
	assign is_numeric  = verdict_q.is_numeric;
	assign has_percent = verdict_q.has_percent;

endmodule

// File: design/nsr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_scan
// Holds the scan phase and percent flag, and works out the next phase and
// the verdict for one character combinationally.
// ----------------------------------------------------------------------------
module nsr_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  nsr_pkg::char_t   ch,
	output nsr_pkg::verdict_t verdict
);
	import nsr_pkg::*;

	phase_t      phase_q;
	logic        percent_q;
	phase_t      phase_d;
	logic        percent_d;
	char_class_t k;

	assign k = classify(ch);

	// Next phase for a non-terminating character.
	always_comb begin
		phase_d = PH_REJECT;
		case (phase_q)
			PH_LEAD: begin
				if (k.is_space)      phase_d = PH_LEAD;
				else if (k.is_sign)  phase_d = PH_SIGN;
				else if (k.is_digit) phase_d = PH_INT;
			end
			PH_SIGN: begin
				if (k.is_digit) phase_d = PH_INT;
			end
			PH_INT: begin
				if (k.is_digit)      phase_d = PH_INT;
				else if (k.is_point) phase_d = PH_FRAC;
				else if (k.is_exp)   phase_d = PH_EXP;
				else if (k.is_pct)   phase_d = PH_PCT;
				else if (k.is_space) phase_d = PH_TRAIL;
			end
			PH_FRAC: begin
				if (k.is_digit)      phase_d = PH_FRAC;
				else if (k.is_exp)   phase_d = PH_EXP;
				else if (k.is_pct)   phase_d = PH_PCT;
				else if (k.is_space) phase_d = PH_TRAIL;
			end
			PH_EXP: begin
				if (k.is_sign)       phase_d = PH_ESIGN;
				else if (k.is_digit) phase_d = PH_EDIG;
			end
			PH_ESIGN: begin
				if (k.is_digit) phase_d = PH_EDIG;
			end
			PH_EDIG: begin
				if (k.is_digit)      phase_d = PH_EDIG;
				else if (k.is_pct)   phase_d = PH_PCT;
				else if (k.is_space) phase_d = PH_TRAIL;
			end
			PH_PCT, PH_TRAIL: begin
				if (k.is_space) phase_d = PH_TRAIL;
			end
			default: begin
				phase_d = PH_REJECT;
			end
		endcase
		percent_d = percent_q || (phase_d == PH_PCT);
	end

	// Verdict as seen at the terminator.
	always_comb begin
		verdict.is_numeric  = (phase_q == PH_INT) || (phase_q == PH_FRAC) ||
			(phase_q == PH_EDIG) || (phase_q == PH_PCT) || (phase_q == PH_TRAIL);
		verdict.has_percent = verdict.is_numeric && percent_q;
	end

	// State update; the terminator rearms for the next string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			percent_q <= 1'b0;
		end else if (step) begin
			if (k.is_nul) begin
				phase_q   <= PH_LEAD;
				percent_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				percent_q <= percent_d;
			end
		end
	end

endmodule
